>>> rtl/core/crsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crsf_pkg;

   // register indexes on the csr port
   localparam logic [3:0] CSR_SYNC_FLIGHT_CTRL = 4'd0;
   localparam logic [3:0] CSR_SYNC_RADIO       = 4'd1;
   localparam logic [3:0] CSR_SYNC_RECEIVER    = 4'd2;
   localparam logic [3:0] CSR_SYNC_TX_MODULE   = 4'd3;

   localparam logic [7:0] SYNC_FLIGHT_CTRL_RST = 8'd200;
   localparam logic [7:0] SYNC_RADIO_RST       = 8'd234;
   localparam logic [7:0] SYNC_RECEIVER_RST    = 8'd236;
   localparam logic [7:0] SYNC_TX_MODULE_RST   = 8'd238;

   localparam logic [7:0] CRC_POLY      = 8'hD5;
   localparam int         MIN_LENGTH    = 2;
   localparam int         TYPE_OFFSET   = 2;
   localparam int         PAYLOAD_OFFSET = 3;
   localparam int         MAX_RESULTS   = 60;

   typedef enum logic [2:0] {
      ST_HUNT,
      ST_LENGTH,
      ST_DATA,
      ST_READ,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic take_len;
      logic take_data;
      logic start_run;
      logic read_issue;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic sync_hit;
      logic len_ok;
      logic frame_done;
      logic crc_ok;
      logic run_last;
   } status_type;

   // one byte through CRC-8 DVB-S2, MSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/crsf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module crsf_ctrl
   import crsf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      req_xfer;
   logic      rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_HUNT: begin
            if (req_xfer && status.sync_hit) state_in = ST_LENGTH;
         end
         ST_LENGTH: begin
            if (req_xfer) begin
               priority if (status.len_ok) state_in = ST_DATA;
               else if (status.sync_hit) state_in = ST_LENGTH;
               else state_in = ST_HUNT;
            end
         end
         ST_DATA: begin
            if (req_xfer && status.frame_done) begin
               state_in = status.crc_ok ? ST_READ : ST_HUNT;
            end
         end
         ST_READ: state_in = ST_SEND;
         ST_SEND: begin
            if (rsp_xfer) state_in = status.run_last ? ST_HUNT : ST_READ;
         end
         default: state_in = ST_HUNT;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         ST_HUNT: req_ready = 1'b1;
         ST_LENGTH: begin
            req_ready    = 1'b1;
            cmd.take_len = req_xfer && status.len_ok;
         end
         ST_DATA: begin
            req_ready     = 1'b1;
            cmd.take_data = req_xfer;
            cmd.start_run = req_xfer && status.frame_done && status.crc_ok;
         end
         ST_READ: cmd.read_issue = 1'b1;
         ST_SEND: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_xfer && !status.run_last;
         end
         default: req_ready = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/crsf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module crsf_datapath
   import crsf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 64
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cmd_type    cmd,
   output status_type      status,
   input  wire logic [7:0] rx_byte,
   input  wire logic       csr_we,
   input  wire logic [3:0] csr_index,
   input  wire logic [7:0] csr_wdata,
   output logic [7:0]      frame_type,
   output logic [5:0]      payload_length,
   output logic [7:0]      payload_byte,
   output logic [5:0]      byte_index,
   output logic            last_of_frame
);

   localparam int AW = $clog2(MAX_FRAME_BYTES);
   localparam int CW = (AW > 6) ? AW : 6;

   logic [7:0]    sync0_ff, sync1_ff, sync2_ff, sync3_ff;
   logic [7:0]    frame_store_mem [MAX_FRAME_BYTES];
   logic [AW-1:0] cnt_ff;
   logic [AW-1:0] len_ff;
   logic [7:0]    crc_ff;
   logic [7:0]    type_ff;
   logic [7:0]    rd_ff;
   logic [5:0]    idx_ff;
   logic [5:0]    last_idx_ff;
   logic [5:0]    last_idx_in;
   logic [CW-1:0] plen;
   logic [AW-1:0] rd_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync0_ff <= SYNC_FLIGHT_CTRL_RST;
         sync1_ff <= SYNC_RADIO_RST;
         sync2_ff <= SYNC_RECEIVER_RST;
         sync3_ff <= SYNC_TX_MODULE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_FLIGHT_CTRL: sync0_ff <= csr_wdata;
            CSR_SYNC_RADIO:       sync1_ff <= csr_wdata;
            CSR_SYNC_RECEIVER:    sync2_ff <= csr_wdata;
            CSR_SYNC_TX_MODULE:   sync3_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign plen    = CW'(len_ff) - CW'(MIN_LENGTH);
   assign rd_addr = AW'(idx_ff) + AW'(PAYLOAD_OFFSET);

   // run length minus one, empty payload still gives one result
   always_comb begin
      priority if (plen == '0) last_idx_in = '0;
      else if (plen > CW'(MAX_RESULTS)) last_idx_in = 6'(MAX_RESULTS - 1);
      else last_idx_in = 6'(plen - CW'(1));
   end

   always_ff @(posedge clock) begin
      if (cmd.take_len) begin
         len_ff <= AW'(rx_byte);
         cnt_ff <= AW'(TYPE_OFFSET);
         crc_ff <= '0;
      end
      if (cmd.take_data) begin
         cnt_ff <= cnt_ff + AW'(1);
         if (cnt_ff == AW'(TYPE_OFFSET)) type_ff <= rx_byte;
         if (!status.frame_done) crc_ff <= crc8_byte(crc_ff, rx_byte);
      end
      if (cmd.start_run) begin
         idx_ff      <= '0;
         last_idx_ff <= last_idx_in;
      end
      if (cmd.advance) idx_ff <= idx_ff + 6'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.take_data) frame_store_mem[cnt_ff] <= rx_byte;
   end

   always_ff @(posedge clock) begin
      if (cmd.read_issue) rd_ff <= frame_store_mem[rd_addr];
   end

   always_comb begin
      status.sync_hit   = (rx_byte == sync0_ff) || (rx_byte == sync1_ff) ||
                          (rx_byte == sync2_ff) || (rx_byte == sync3_ff);
      status.len_ok     = ({1'b0, rx_byte} >= 9'(MIN_LENGTH)) &&
                          ({1'b0, rx_byte} <= 9'(MAX_FRAME_BYTES - MIN_LENGTH));
      status.frame_done = cnt_ff == (len_ff + AW'(1));
      status.crc_ok     = crc_ff == rx_byte;
      status.run_last   = idx_ff == last_idx_ff;
   end

   assign frame_type     = type_ff;
   assign payload_length = plen[5:0];
   assign payload_byte   = (plen == '0) ? 8'd0 : rd_ff;
   assign byte_index     = idx_ff;
   assign last_of_frame  = status.run_last;

endmodule

`default_nettype wire

>>> rtl/core/crsf_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none

// CRSF frame receiver.
// req_*: one serial byte per transfer. The block hunts for a sync byte that
//   matches one of four csr addresses, takes the length byte (2 to
//   MAX_FRAME_BYTES-2, a bad one resyncs on itself if it is a sync byte),
//   then type, payload and CRC. CRC-8 DVB-S2 runs one byte per transfer.
// rsp_*: a good frame comes out as a run, one transfer per payload byte
//   (one transfer with payload_byte zero for an empty payload), capped at
//   60, last_of_frame on the final one. Bad CRC frames vanish silently.
// csr_*: index 0..3 selects a sync address; other indexes are dropped.
//   csr_ready is always high.
// Flow: while parsing, req_ready is held high and every input byte is taken
//   as offered. After the CRC byte each result passes through a registered
//   frame store read (ST_READ) and is then held on rsp_* (ST_SEND) until
//   rsp_ready, and req_ready stays low for the whole run. A stalled receiver
//   just holds the current result. The first result follows the CRC byte
//   transfer through ST_READ into ST_SEND.
// Reset: synchronous, active high; parser back to hunting, sync addresses
//   to 200, 234, 236, 238. The frame store needs no clearing.
module crsf_frame_receiver
   import crsf_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 64
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_frame_type,
   output logic [5:0]      rsp_payload_length,
   output logic [7:0]      rsp_payload_byte,
   output logic [5:0]      rsp_byte_index,
   output logic            rsp_last_of_frame,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [3:0] csr_index,
   input  wire logic [7:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   crsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   crsf_datapath #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .rx_byte        (req_rx_byte),
      .csr_we         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .frame_type     (rsp_frame_type),
      .payload_length (rsp_payload_length),
      .payload_byte   (rsp_payload_byte),
      .byte_index     (rsp_byte_index),
      .last_of_frame  (rsp_last_of_frame)
   );

`ifndef SYNTHESIS
   // parsing and emitting never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("input accepted during result run");

   // results of one run come with consecutive indexes
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_frame |-> ##2
      (rsp_valid && rsp_byte_index == $past(rsp_byte_index, 2) + 6'd1))
      else $error("byte_index did not advance by one");

   // after the last transfer the parser hunts again
   a_back_to_hunt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_frame |=> req_ready && !rsp_valid)
      else $error("parser not ready after end of run");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import crsf_pkg::*;

   // Frame store depth of the block as instantiated (default parameter).
   localparam int FRAME_BYTES = 64;
   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;
   // Settle time after the last expected result; a bad-CRC frame ends without any result.
   localparam int SETTLE_CYCLES = 8;
   // Long receiver hold-off so the block stalls in a result run and back-pressures req_*.
   localparam int LONG_HOLD_CYCLES = 400;

   // csr indexes with no register behind them
   localparam logic [3:0] CSR_UNMAPPED_LO = 4'd4;
   localparam logic [3:0] CSR_UNMAPPED_HI = 4'd15;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [7:0] frame_type;
      logic [5:0] payload_length;
      logic [7:0] payload_byte;
      logic [5:0] byte_index;
      logic       last_of_frame;
   } frame_result_type;

   typedef enum logic [1:0] {
      HUNT_SYNC,
      TAKE_LENGTH,
      TAKE_BODY
   } parse_phase_type;

   // ------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_frame_type;
   logic [5:0] rsp_payload_length;
   logic [7:0] rsp_payload_byte;
   logic [5:0] rsp_byte_index;
   logic       rsp_last_of_frame;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [3:0] csr_index = 4'd0;
   logic [7:0] csr_wdata = 8'h00;

   crsf_frame_receiver uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // ------------------------------------------------------------------
   // Shared bookkeeping
   // ------------------------------------------------------------------
   byte_q_type       rx_bytes_pending;       // bytes waiting for the driver
   frame_result_type expected_results[$];    // predicted results, oldest first
   int unsigned      bytes_queued = 0;
   int unsigned      bytes_accepted = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      cycle_count = 0;
   bit               sender_gaps_on = 1'b0;
   bit               receiver_stalls_on = 1'b0;
   int unsigned      hold_request = 0;       // set by the sequencer, consumed by rsp_ready

   // ------------------------------------------------------------------
   // Frame parser prediction: own copy of the sync addresses and parser
   // ------------------------------------------------------------------
   logic [7:0]      sync_addr_cfg [4] = '{SYNC_FLIGHT_CTRL_RST, SYNC_RADIO_RST,
                                          SYNC_RECEIVER_RST, SYNC_TX_MODULE_RST};
   parse_phase_type parse_phase = HUNT_SYNC;
   int unsigned     body_count = 0;
   int unsigned     frame_len = 0;
   logic [7:0]      frame_buf [FRAME_BYTES];

   // CRC-8 DVB-S2, MSB first, one byte
   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] acc;
      logic       msb;
      acc = crc ^ data;
      for (int bitpos = 0; bitpos < 8; bitpos++) begin
         msb = acc[7];
         acc = {acc[6:0], 1'b0};
         if (msb) begin
            acc = acc ^ CRC_POLY;
         end
      end
      return acc;
   endfunction

   function automatic bit is_sync(input logic [7:0] b);
      return b == sync_addr_cfg[0] || b == sync_addr_cfg[1] ||
             b == sync_addr_cfg[2] || b == sync_addr_cfg[3];
   endfunction

   // back to hunting; a sync byte opens a new frame right away
   task automatic resync_on(input logic [7:0] b);
      parse_phase = HUNT_SYNC;
      if (is_sync(b)) begin
         frame_buf[0] = b;
         body_count   = 1;
         parse_phase  = TAKE_LENGTH;
      end
   endtask

   task automatic predict_byte(input logic [7:0] b);
      logic [7:0]       crc;
      int unsigned      plen;
      int unsigned      runs;
      frame_result_type res;
      case (parse_phase)
         TAKE_LENGTH: begin
            if (b >= MIN_LENGTH && b <= FRAME_BYTES - 2) begin
               frame_buf[1] = b;
               frame_len    = b;
               body_count   = 2;
               parse_phase  = TAKE_BODY;
            end else begin
               resync_on(b);
            end
         end
         TAKE_BODY: begin
            if (body_count < FRAME_BYTES) begin
               frame_buf[body_count] = b;
            end
            body_count++;
            if (body_count >= frame_len + 2 || body_count >= FRAME_BYTES) begin
               parse_phase = HUNT_SYNC;
               // CRC covers type and payload: length byte minus one bytes
               crc = 8'h00;
               for (int unsigned i = 0; i < frame_len - 1; i++) begin
                  crc = crc_step(crc, frame_buf[TYPE_OFFSET + i]);
               end
               if (crc == b) begin
                  plen = frame_len - 2;
                  runs = (plen == 0) ? 1 : plen;
                  if (runs > MAX_RESULTS) begin
                     runs = MAX_RESULTS;
                  end
                  for (int unsigned i = 0; i < runs; i++) begin
                     res.frame_type     = frame_buf[TYPE_OFFSET];
                     res.payload_length = plen[5:0];
                     res.payload_byte   = (plen == 0) ? 8'h00 : frame_buf[PAYLOAD_OFFSET + i];
                     res.byte_index     = i[5:0];
                     res.last_of_frame  = (i + 1 == runs);
                     expected_results.push_back(res);
                  end
               end
            end
         end
         default: begin
            resync_on(b);
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Random shaping
   // ------------------------------------------------------------------
   // mostly no gap, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // small payloads dominate; a few reach the 60 byte ceiling
   function automatic int unsigned pick_payload_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(0, 8);
      if (r < 95) return $urandom_range(9, 30);
      return $urandom_range(31, 60);
   endfunction

   function automatic logic [7:0] pick_bad_length();
      case ($urandom_range(0, 3))
         0:       return 8'd0;
         1:       return 8'd1;
         default: return 8'($urandom_range(FRAME_BYTES - 1, 255));
      endcase
   endfunction

   // payload content; now and then a sync byte lands inside the frame
   function automatic byte_q_type random_body(input int unsigned n);
      byte_q_type body;
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            body.push_back(sync_addr_cfg[$urandom_range(0, 3)]);
         end else begin
            body.push_back(8'($urandom_range(0, 255)));
         end
      end
      return body;
   endfunction

   task automatic push_byte(input logic [7:0] b);
      rx_bytes_pending.push_back(b);
      bytes_queued++;
   endtask

   task automatic push_frame(input logic [7:0] sync, input logic [7:0] ftype,
                             input byte_q_type body, input bit bad_crc);
      logic [7:0] crc;
      crc = crc_step(8'h00, ftype);
      foreach (body[i]) begin
         crc = crc_step(crc, body[i]);
      end
      if (bad_crc) begin
         crc = crc ^ (8'h01 << $urandom_range(0, 7));
      end
      push_byte(sync);
      push_byte(8'(body.size() + 2));
      push_byte(ftype);
      foreach (body[i]) begin
         push_byte(body[i]);
      end
      push_byte(crc);
   endtask

   // Mostly well-formed frames with random content, the rest bad CRCs,
   // bad length bytes, truncated frames and line noise.
   task automatic queue_random_traffic(input int unsigned target);
      int unsigned start_count;
      int unsigned r;
      start_count = bytes_queued;
      while (bytes_queued - start_count < target) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            push_frame(sync_addr_cfg[$urandom_range(0, 3)], 8'($urandom_range(0, 255)),
                       random_body(pick_payload_len()), r >= 70);
         end else if (r < 88) begin
            push_byte(sync_addr_cfg[$urandom_range(0, 3)]);
            push_byte(pick_bad_length());
         end else if (r < 92) begin
            // header promises more than is sent; the next bytes get swallowed
            push_byte(sync_addr_cfg[$urandom_range(0, 3)]);
            push_byte(8'($urandom_range(3, 20)));
            repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequencer helpers
   // ------------------------------------------------------------------
   // csr write; the predictor copy is updated at the transfer edge
   task automatic write_csr(input logic [3:0] idx, input logic [7:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_SYNC_FLIGHT_CTRL: sync_addr_cfg[0] = data;
         CSR_SYNC_RADIO:       sync_addr_cfg[1] = data;
         CSR_SYNC_RECEIVER:    sync_addr_cfg[2] = data;
         CSR_SYNC_TX_MODULE:   sync_addr_cfg[3] = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // all bytes taken, all results in, then let the parser settle
   task automatic wait_drained();
      do @(negedge clock);
      while (bytes_accepted != bytes_queued || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Driver: one byte per req transfer, random gaps between bytes
   // ------------------------------------------------------------------
   int unsigned send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_byte(req_rx_byte);
            bytes_accepted++;
         end
         // valid is only touched once the current byte has gone
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (rx_bytes_pending.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_bytes_pending.pop_front();
               send_gap = sender_gaps_on ? pick_gap() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver back-pressure: random stalls plus the requested long hold
   // ------------------------------------------------------------------
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (hold_request != 0) begin
         stall_left = hold_request;
         hold_request = 0;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (receiver_stalls_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: every rsp transfer against the oldest prediction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      frame_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: unexpected result type %02h len %0d byte %02h idx %0d last %0b",
                        $time, rsp_frame_type, rsp_payload_length, rsp_payload_byte,
                        rsp_byte_index, rsp_last_of_frame);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_frame_type !== want.frame_type ||
                rsp_payload_length !== want.payload_length ||
                rsp_payload_byte !== want.payload_byte ||
                rsp_byte_index !== want.byte_index ||
                rsp_last_of_frame !== want.last_of_frame) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch exp type %02h len %0d byte %02h idx %0d last %0b",
                           $time, want.frame_type, want.payload_length, want.payload_byte,
                           want.byte_index, want.last_of_frame);
                  $display("%0t:          got type %02h len %0d byte %02h idx %0d last %0b",
                           $time, rsp_frame_type, rsp_payload_length, rsp_payload_byte,
                           rsp_byte_index, rsp_last_of_frame);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   initial begin : sequencer
      byte_q_type body;
      logic [7:0] split_type;
      logic [7:0] split_crc;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed, reset addresses --------------------------------
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      // noise while hunting
      push_byte(8'h00);
      push_byte(8'hFF);
      // empty payload: one result with a zero payload byte
      body.delete();
      push_frame(SYNC_FLIGHT_CTRL_RST, 8'hFF, body, 1'b0);
      // bad length that is itself a sync byte starts the next frame;
      // that frame carries a sync value as payload
      push_byte(SYNC_RADIO_RST);
      body.delete();
      body.push_back(SYNC_RECEIVER_RST);
      push_frame(SYNC_FLIGHT_CTRL_RST, 8'h00, body, 1'b0);
      // lengths outside the legal range: one just past the top end, and zero
      push_byte(SYNC_TX_MODULE_RST);
      push_byte(8'(FRAME_BYTES - 1));
      push_byte(SYNC_FLIGHT_CTRL_RST);
      push_byte(8'd0);
      // corrupted CRC, silently dropped
      body.delete();
      body.push_back(8'h55);
      push_frame(SYNC_TX_MODULE_RST, 8'h10, body, 1'b1);
      body.delete();
      body.push_back(8'hFF);
      body.push_back(8'h00);
      push_frame(SYNC_TX_MODULE_RST, 8'h80, body, 1'b0);
      wait_drained();

      // --- extreme addresses, unmapped indexes ----------------------
      write_csr(CSR_SYNC_FLIGHT_CTRL, 8'h00);
      write_csr(CSR_SYNC_RADIO, 8'hFF);
      write_csr(CSR_SYNC_RECEIVER, 8'h5A);
      write_csr(CSR_SYNC_TX_MODULE, 8'hA5);
      write_csr(CSR_UNMAPPED_LO, 8'($urandom_range(0, 255)));
      write_csr(CSR_UNMAPPED_HI, 8'($urandom_range(0, 255)));
      @(negedge clock);
      // longest legal frame: 60 payload bytes, the full result run
      push_frame(sync_addr_cfg[1], 8'($urandom_range(0, 255)), random_body(MAX_RESULTS), 1'b0);
      queue_random_traffic(25);
      wait_drained();

      // --- address change with a frame half received ----------------
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b0;
      split_type = 8'h3C;
      push_byte(sync_addr_cfg[3]);
      push_byte(8'd4);
      push_byte(split_type);
      wait_drained();
      write_csr(CSR_SYNC_TX_MODULE, 8'h11);
      @(negedge clock);
      // rest of that frame still parses; payload holds a sync value
      split_crc = crc_step(crc_step(crc_step(8'h00, split_type), 8'h7E), 8'h00);
      push_byte(8'h7E);
      push_byte(8'h00);
      push_byte(split_crc);
      // new address opens frames, the old one is plain noise now
      push_frame(8'h11, 8'h21, random_body(3), 1'b0);
      push_byte(8'hA5);
      queue_random_traffic(25);
      wait_drained();

      // --- random addresses, long receiver hold-off ------------------
      write_csr(CSR_SYNC_FLIGHT_CTRL, 8'($urandom_range(0, 255)));
      write_csr(CSR_SYNC_RADIO, 8'($urandom_range(0, 255)));
      write_csr(CSR_SYNC_RECEIVER, 8'($urandom_range(0, 255)));
      write_csr(CSR_SYNC_TX_MODULE, 8'($urandom_range(0, 255)));
      @(negedge clock);
      receiver_stalls_on = 1'b1;
      push_frame(sync_addr_cfg[0], 8'($urandom_range(0, 255)), random_body(12), 1'b0);
      queue_random_traffic(35);
      hold_request = LONG_HOLD_CYCLES;
      wait_drained();

      // --- back to reset addresses, no idling on either side ---------
      write_csr(CSR_SYNC_FLIGHT_CTRL, SYNC_FLIGHT_CTRL_RST);
      write_csr(CSR_SYNC_RADIO, SYNC_RADIO_RST);
      write_csr(CSR_SYNC_RECEIVER, SYNC_RECEIVER_RST);
      write_csr(CSR_SYNC_TX_MODULE, SYNC_TX_MODULE_RST);
      @(negedge clock);
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      queue_random_traffic(25);
      wait_drained();

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/crsf_pkg.sv
rtl/core/crsf_ctrl.sv
rtl/core/crsf_datapath.sv
rtl/core/crsf_frame_receiver.sv
tb/sv/tb_top.sv
